### hw/rtl/assert_macros.svh
// Assertion macros for the checker file dwm_checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on a clock, masked while reset is asserted.
`define DWM_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("dwm check failed");

// Implication whose consequent holds in the cycle after the antecedent.
`define DWM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	`DWM_ASSERT(lbl, clk, rst_n, (ante) |=> (cons))

`endif

### hw/rtl/dwm_pkg.sv
// Shared types, constants and helpers for the DOS wildcard name matcher.
// No dependencies.
`timescale 1ns / 1ps

package dwm_pkg;

	localparam int PATTERN_MAX = 32;
	localparam int CNT_W       = $clog2(PATTERN_MAX + 1);

	localparam logic [7:0] CH_STAR     = 8'h2A;
	localparam logic [7:0] CH_QUESTION = 8'h3F;
	localparam logic [7:0] CH_DOT      = 8'h2E;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_NAME   = 2'd2,
		OP_END    = 2'd3
	} op_t;

	typedef struct packed {
		logic       restart;
		logic       step;
		logic       clear;
		logic [7:0] name_byte;
	} cell_ctl_t;

	typedef struct packed {
		logic carry;
		logic adv;
	} link_t;

	function automatic logic [7:0] fold(input logic [7:0] c);
		fold = (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
	endfunction

endpackage

### hw/rtl/dwm_cell.sv
// One pattern position: stored byte, valid bit and live state bit.
// Depends on dwm_pkg.
`timescale 1ns / 1ps

module dwm_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  dwm_pkg::cell_ctl_t ctl,
	input  logic              load,
	input  logic [7:0]        load_byte,
	input  dwm_pkg::link_t    link_in,
	output dwm_pkg::link_t    link_out,
	output logic              closed,
	output logic [7:0]        pat_byte
);
	import dwm_pkg::*;

	logic       valid_q;
	logic [7:0] byte_q;
	logic       raw_q;
	logic       star;
	logic       hit;

	assign star     = valid_q && (byte_q == CH_STAR);
	assign hit      = valid_q && !star &&
	                  ((byte_q == CH_QUESTION) || (fold(byte_q) == fold(ctl.name_byte)));
	assign closed   = raw_q | link_in.carry;
	assign link_out = '{carry: closed & star, adv: closed & hit};
	assign pat_byte = byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			raw_q   <= 1'b0;
		end else begin
			if (ctl.clear) begin
				valid_q <= 1'b0;
			end else if (load) begin
				valid_q <= 1'b1;
			end
			if (ctl.restart) begin
				raw_q <= 1'b0;
			end else if (ctl.step) begin
				raw_q <= link_in.adv | (closed & star);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= load_byte;
		end
	end

endmodule

### hw/rtl/dos_wildcard_name_matcher.sv
// Top level of the DOS wildcard name matcher: op decode, name state, cell row, result register.
// Depends on dwm_pkg and dwm_cell.
//
//   beat    | handshake          | payload
//   input   | in_valid/in_ready  | op, data_byte
//   output  | out_valid/out_ready| matched, pattern_overflow
//
// One input beat per cycle while in_ready is high; an end-of-name beat shows its result the next cycle.
// Each name byte updates every cell of the row together, star closure rippling cell to cell.
// in_ready drops only while a result is held and out_ready is low.
// Reset leaves an empty pattern and a fresh name; no clearing pass.
`timescale 1ns / 1ps

module dos_wildcard_name_matcher (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] op,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       matched,
	output logic       pattern_overflow
);
	import dwm_pkg::*;

	logic                  accept;
	logic                  do_clear, do_append, do_name, do_end;
	logic                  room;
	cell_ctl_t             ctl;
	link_t                 links [PATTERN_MAX+1];
	logic [PATTERN_MAX:0]  closed;
	logic [7:0]            pat_bytes [PATTERN_MAX];

	logic [CNT_W-1:0]      count_q;
	logic [7:0]            last_q;
	logic                  overflow_q;
	logic                  head_q;
	logic                  tail_q;
	logic                  has_dot_q;
	logic [1:0]            short_len_q;
	logic                  all_dots_q;

	logic                  out_valid_q;
	logic                  matched_q;
	logic                  overflow_out_q;

	logic                  star_dot_star;
	logic                  last_dot;
	logic                  dot_name;
	logic [CNT_W-1:0]      acc_idx;
	logic                  decision;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign room     = count_q < CNT_W'(PATTERN_MAX);

	always_comb begin
		do_clear  = 1'b0;
		do_append = 1'b0;
		do_name   = 1'b0;
		do_end    = 1'b0;
		unique case (op_t'(op))
			OP_CLEAR:  do_clear  = accept;
			OP_APPEND: do_append = accept;
			OP_NAME:   do_name   = accept;
			OP_END:    do_end    = accept;
			default:   do_end    = 1'b0;
		endcase
	end

	assign ctl = '{restart: do_clear | do_append | do_end,
	               step: do_name,
	               clear: do_clear,
	               name_byte: data_byte};

	assign links[0] = '{carry: head_q, adv: 1'b0};

	for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
		dwm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.load      (do_append && (count_q == CNT_W'(i))),
			.load_byte (data_byte),
			.link_in   (links[i]),
			.link_out  (links[i+1]),
			.closed    (closed[i]),
			.pat_byte  (pat_bytes[i])
		);
	end

	assign closed[PATTERN_MAX] = tail_q | links[PATTERN_MAX].carry;

	assign star_dot_star = (count_q == CNT_W'(3)) && (pat_bytes[0] == CH_STAR) &&
	                       (pat_bytes[1] == CH_DOT) && (pat_bytes[2] == CH_STAR);
	assign last_dot  = last_q == CH_DOT;
	assign dot_name  = all_dots_q && ((short_len_q == 2'd1) || (short_len_q == 2'd2));
	assign acc_idx   = count_q - CNT_W'(last_dot);

	always_comb begin
		if (overflow_q) begin
			decision = 1'b0;
		end else if (count_q == '0 || star_dot_star) begin
			decision = 1'b1;
		end else if (last_dot && !dot_name && has_dot_q) begin
			decision = 1'b0;
		end else begin
			decision = closed[acc_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			overflow_q  <= 1'b0;
			head_q      <= 1'b1;
			tail_q      <= 1'b0;
			has_dot_q   <= 1'b0;
			short_len_q <= 2'd0;
			all_dots_q  <= 1'b1;
		end else begin
			if (do_clear) begin
				count_q    <= '0;
				overflow_q <= 1'b0;
			end else if (do_append) begin
				if (room) begin
					count_q <= count_q + CNT_W'(1);
				end else begin
					overflow_q <= 1'b1;
				end
			end
			if (ctl.restart) begin
				head_q      <= 1'b1;
				tail_q      <= 1'b0;
				has_dot_q   <= 1'b0;
				short_len_q <= 2'd0;
				all_dots_q  <= 1'b1;
			end else if (do_name) begin
				head_q <= 1'b0;
				tail_q <= links[PATTERN_MAX].adv;
				if (data_byte == CH_DOT) begin
					has_dot_q <= 1'b1;
				end else begin
					all_dots_q <= 1'b0;
				end
				if (short_len_q != 2'd3) begin
					short_len_q <= short_len_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_append && room) begin
			last_q <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_end) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_end) begin
			matched_q      <= decision;
			overflow_out_q <= overflow_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign matched          = matched_q;
	assign pattern_overflow = overflow_out_q;

endmodule

### hw/rtl/dwm_checker.sv
// Port-level checks for the DOS wildcard name matcher, bound to the top level.
// Depends on dwm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dwm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [1:0] op,
	input logic [7:0] data_byte,
	input logic       out_valid,
	input logic       out_ready,
	input logic       matched,
	input logic       pattern_overflow
);
	import dwm_pkg::*;

	logic acc_clear;
	logic acc_end;

	assign acc_clear = in_valid && in_ready && (op == OP_CLEAR);
	assign acc_end   = in_valid && in_ready && (op == OP_END) && (data_byte == data_byte);

	`DWM_ASSERT_NEXT(a_hold_stalled, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(matched) && $stable(pattern_overflow))
	`DWM_ASSERT_NEXT(a_end_gives_beat, clk, arst_n, acc_end, out_valid)
	`DWM_ASSERT(a_overflow_no_match, clk, arst_n, (out_valid && pattern_overflow) |-> !matched)
	`DWM_ASSERT_NEXT(a_empty_matches, clk, arst_n, acc_clear ##1 acc_end,
		out_valid && matched && !pattern_overflow)

endmodule

bind dos_wildcard_name_matcher dwm_checker u_dwm_checker (.*);

### tb/sv/dwm_match_checker.sv
// Checker for the DOS wildcard name matcher: watches both channels, predicts each result.
// Depends on dwm_pkg; instantiated next to the block by tb_dos_wildcard_name_matcher.
`timescale 1ns / 1ps

module dwm_match_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [1:0] op,
	input  logic [7:0] data_byte,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic       matched,
	input  logic       pattern_overflow,
	output int         mismatch_count,
	output int         results_pending,
	output int         names_checked
);
	import dwm_pkg::*;

	typedef struct packed {
		logic matched;
		logic overflow;
	} verdict_t;

	logic [7:0]         pat_bytes [PATTERN_MAX];
	int                 pat_len;
	logic               pat_over;
	logic [PATTERN_MAX:0] live;
	logic               saw_dot;
	logic               only_dots;
	logic [1:0]         name_len;
	verdict_t           verdicts_due [$];

	function automatic logic [7:0] lower_ascii(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
	endfunction

	function automatic logic [PATTERN_MAX:0] close_over_stars(input logic [PATTERN_MAX:0] v);
		for (int i = 0; i < pat_len; i++)
			if (v[i] && pat_bytes[i] == CH_STAR)
				v[i+1] = 1'b1;
		return v;
	endfunction

	function automatic logic [PATTERN_MAX:0] step_positions(input logic [7:0] c);
		logic [PATTERN_MAX:0] next;
		next = '0;
		for (int i = 0; i < pat_len; i++) begin
			if (live[i]) begin
				if (pat_bytes[i] == CH_STAR)
					next[i] = 1'b1;
				else if (pat_bytes[i] == CH_QUESTION || lower_ascii(pat_bytes[i]) == lower_ascii(c))
					next[i+1] = 1'b1;
			end
		end
		return close_over_stars(next);
	endfunction

	function automatic void fresh_name();
		live = close_over_stars({{PATTERN_MAX{1'b0}}, 1'b1});
		saw_dot = 1'b0;
		only_dots = 1'b1;
		name_len = 2'd0;
	endfunction

	function automatic verdict_t name_verdict();
		verdict_t v;
		int       acc;
		logic     dot_name;
		v.overflow = pat_over;
		v.matched = 1'b0;
		acc = pat_len;
		if (pat_over)
			return v;
		if (pat_len == 0 || (pat_len == 3 && pat_bytes[0] == CH_STAR &&
				pat_bytes[1] == CH_DOT && pat_bytes[2] == CH_STAR)) begin
			v.matched = 1'b1;
			return v;
		end
		if (pat_bytes[pat_len-1] == CH_DOT) begin
			dot_name = only_dots && (name_len == 2'd1 || name_len == 2'd2);
			if (!dot_name && saw_dot)
				return v;
			acc = pat_len - 1;
		end
		v.matched = live[acc];
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		if (!arst_n) begin
			pat_len = 0;
			pat_over = 1'b0;
			fresh_name();
			verdicts_due.delete();
			mismatch_count = 0;
			results_pending = 0;
			names_checked = 0;
		end else begin
			if (out_valid && out_ready) begin
				names_checked++;
				if (verdicts_due.size() == 0) begin
					$display("%0t: unexpected result beat matched=%0b pattern_overflow=%0b",
						$time, matched, pattern_overflow);
					mismatch_count++;
				end else begin
					want = verdicts_due.pop_front();
					if (matched !== want.matched) begin
						$display("%0t: matched expected %0b actual %0b",
							$time, want.matched, matched);
						mismatch_count++;
					end
					if (pattern_overflow !== want.overflow) begin
						$display("%0t: pattern_overflow expected %0b actual %0b",
							$time, want.overflow, pattern_overflow);
						mismatch_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				case (op_t'(op))
				OP_CLEAR: begin
					pat_len = 0;
					pat_over = 1'b0;
					fresh_name();
				end
				OP_APPEND: begin
					if (pat_len < PATTERN_MAX) begin
						pat_bytes[pat_len] = data_byte;
						pat_len++;
					end else begin
						pat_over = 1'b1;
					end
					fresh_name();
				end
				OP_NAME: begin
					live = step_positions(data_byte);
					if (data_byte == CH_DOT)
						saw_dot = 1'b1;
					else
						only_dots = 1'b0;
					if (name_len < 2'd3)
						name_len++;
				end
				default: begin
					verdicts_due.insert(verdicts_due.size(), name_verdict());
					fresh_name();
				end
				endcase
			end
			results_pending = verdicts_due.size();
		end
	end

endmodule

### tb/sv/tb_dos_wildcard_name_matcher.sv
// Testbench top for the DOS wildcard name matcher: clock, reset, pattern and name stimulus.
// Depends on dwm_pkg, dos_wildcard_name_matcher and dwm_match_checker.
`timescale 1ns / 1ps

module tb_dos_wildcard_name_matcher;
	import dwm_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	op_t        op_in = OP_CLEAR;
	logic [7:0] data_byte = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       matched;
	logic       pattern_overflow;
	logic       no_gaps = 1'b0;

	int mismatch_count;
	int results_pending;
	int names_checked;
	int beats_sent = 0;
	int patterns_loaded = 0;

	logic [7:0] pat_buf [$];
	logic [7:0] name_buf [$];

	dos_wildcard_name_matcher DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.op               (op_in),
		.data_byte        (data_byte),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.matched          (matched),
		.pattern_overflow (pattern_overflow)
	);

	dwm_match_checker checker_i (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.op               (op_in),
		.data_byte        (data_byte),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.matched          (matched),
		.pattern_overflow (pattern_overflow),
		.mismatch_count   (mismatch_count),
		.results_pending  (results_pending),
		.names_checked    (names_checked)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		out_ready <= no_gaps || ($urandom_range(99) >= 30);
	end

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	task automatic send_beat(input op_t kind, input logic [7:0] b);
		if (!no_gaps && $urandom_range(99) < 30) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid <= 1'b1;
		op_in <= kind;
		data_byte <= b;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		beats_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		wait (results_pending == 0);
		@(negedge clk);
	endtask

	task automatic load_pattern(input string s);
		send_beat(OP_CLEAR, 8'($urandom_range(255)));
		for (int i = 0; i < s.len(); i++)
			send_beat(OP_APPEND, s[i]);
		patterns_loaded++;
	endtask

	task automatic send_name(input string s);
		for (int i = 0; i < s.len(); i++)
			send_beat(OP_NAME, s[i]);
		send_beat(OP_END, 8'($urandom_range(255)));
	endtask

	function automatic logic [7:0] any_letter();
		return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'($urandom_range(25));
	endfunction

	function automatic logic [7:0] pattern_char();
		int r;
		r = $urandom_range(99);
		if (r < 20)
			return CH_STAR;
		if (r < 32)
			return CH_QUESTION;
		if (r < 44)
			return CH_DOT;
		if (r < 80)
			return any_letter();
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [7:0] name_char();
		int r;
		r = $urandom_range(99);
		if (r < 40)
			return any_letter();
		if (r < 60)
			return CH_DOT;
		if (r < 70)
			return CH_STAR;
		return 8'($urandom_range(255));
	endfunction

	function automatic void build_pattern(input logic force_over);
		int r;
		int len;
		pat_buf.delete();
		r = $urandom_range(99);
		if (force_over || r < 6) begin
			len = PATTERN_MAX + $urandom_range(1, 2);
			repeat (len) pat_buf.insert(pat_buf.size(), pattern_char());
		end else if (r < 14) begin
			pat_buf = '{CH_STAR, CH_DOT, CH_STAR};
		end else begin
			len = $urandom_range(0, 7);
			repeat (len) pat_buf.insert(pat_buf.size(), pattern_char());
			if ($urandom_range(99) < 25)
				pat_buf.insert(pat_buf.size(), CH_DOT);
		end
	endfunction

	function automatic void build_name();
		int         r;
		logic [7:0] c;
		name_buf.delete();
		r = $urandom_range(99);
		if (r < 55) begin
			foreach (pat_buf[i]) begin
				c = pat_buf[i];
				if (c == CH_STAR) begin
					repeat ($urandom_range(0, 2)) name_buf.insert(name_buf.size(), name_char());
				end else if (c == CH_QUESTION) begin
					name_buf.insert(name_buf.size(), 8'($urandom_range(255)));
				end else begin
					if (((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) &&
							$urandom_range(1))
						c = c ^ 8'h20;
					name_buf.insert(name_buf.size(), c);
				end
			end
			if (name_buf.size() > 0 && $urandom_range(99) < 15)
				name_buf[$urandom_range(name_buf.size() - 1)] = name_char();
		end else if (r < 65) begin
			name_buf.insert(name_buf.size(), CH_DOT);
		end else if (r < 72) begin
			name_buf = '{CH_DOT, CH_DOT};
		end else begin
			repeat ($urandom_range(0, 6)) name_buf.insert(name_buf.size(), name_char());
		end
	endfunction

	initial begin
		int phase;
		phase = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty pattern, empty name
		send_beat(OP_END, 8'h00);
		load_pattern("*.*");
		send_beat(OP_NAME, 8'hFF);
		send_beat(OP_NAME, 8'h00);
		send_beat(OP_END, 8'hFF);
		load_pattern("*.");
		send_name(".");
		send_name("..");
		send_name("a.b");
		load_pattern("a*C");
		send_name("A*c");
		send_name("");
		// pattern grows while a name is in flight
		send_beat(OP_NAME, "x");
		send_beat(OP_APPEND, "?");
		send_name("abcd");

		while (beats_sent < 380) begin
			build_pattern(phase == 0);
			send_beat(OP_CLEAR, 8'($urandom_range(255)));
			foreach (pat_buf[i])
				send_beat(OP_APPEND, pat_buf[i]);
			patterns_loaded++;
			if (phase == 5)
				drain_results();
			repeat ($urandom_range(1, 5)) begin
				build_name();
				foreach (name_buf[i]) begin
					if ($urandom_range(99) < 3)
						send_beat($urandom_range(1) ? OP_CLEAR : OP_APPEND,
							8'($urandom_range(255)));
					send_beat(OP_NAME, name_buf[i]);
				end
				send_beat(OP_END, 8'($urandom_range(255)));
			end
			phase++;
			no_gaps = (phase >= 12 && phase < 22);
		end

		in_valid <= 1'b0;
		wait (results_pending == 0);
		repeat (20) @(posedge clk);
		$display("Sent %0d beats over %0d patterns, including overflow and trailing-dot cases.",
			beats_sent, patterns_loaded);
		$display("Checked %0d end-of-name results, %0d mismatches.", names_checked, mismatch_count);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

### dos_wildcard_name_matcher.f
+incdir+hw/rtl
hw/rtl/dwm_pkg.sv
hw/rtl/dwm_cell.sv
hw/rtl/dos_wildcard_name_matcher.sv
hw/rtl/dwm_checker.sv
tb/sv/dwm_match_checker.sv
tb/sv/tb_dos_wildcard_name_matcher.sv
